@@ design/text_console_writer_defines.svh @@
// Assertion macros of the text console writer, used by its port checks.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TCW_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/tcw_pkg.sv @@
// Shared constants, types and helpers of the text console writer.
package tcw_pkg;

  // Grid geometry.
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);

  // Field widths.
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;

  // Opcodes.
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_SET   = 2'd2;
  localparam logic [OP_W-1:0] OP_READ  = 2'd3;

  // Control characters and the blank.
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_COPY, ST_FILL} state_t;

  // Linear cell index of a column and row.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                  input logic [ROW_W-1:0] row);
    return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

@@ design/tcw_cell_ram.sv @@
// Cell memory of the text console: one write port, one registered read port.
module tcw_cell_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [tcw_pkg::ADDR_W-1:0]   waddr,
  input  logic [tcw_pkg::CELL_W-1:0]   wdata,
  input  logic [tcw_pkg::ADDR_W-1:0]   raddr,
  output logic [tcw_pkg::CELL_W-1:0]   rdata
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [CELL_COUNT];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ design/text_console_writer.sv @@
// Top level of the text console writer: command decode, cursor and grid sequencer.
//
//  channel   direction  handshake                 beat
//  command   in         start & !busy             opcode, char_code, target_col, target_row
//  result    out        done (one cycle strobe)   cursor_col, cursor_row, cursor_position,
//                                                 cell_data, scrolled
//  config    in         cfg_valid & cfg_ready     color_attribute
//
// Put (no scroll) and set cursor answer in the cycle after they are taken; read cell
// answers through the registered read port of the cell memory. A scroll copies the grid up
// one cell per cycle through that port and then blanks the last row. Clear blanks one
// cell per cycle. After reset the block blanks the grid with busy high.
// The result is registered and shown for one cycle; the receiver cannot stall.
module text_console_writer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [tcw_pkg::OP_W-1:0]    opcode,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
  input  logic [tcw_pkg::COL_W-1:0]   target_col,
  input  logic [tcw_pkg::ROW_W-1:0]   target_row,
  output logic                        done,
  output logic [tcw_pkg::COL_W-1:0]   cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]   cursor_row,
  output logic [tcw_pkg::POS_W-1:0]   cursor_position,
  output logic [tcw_pkg::CELL_W-1:0]  cell_data,
  output logic                        scrolled,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tcw_pkg::ATTR_W-1:0]  color_attribute
);
  import tcw_pkg::*;

  state_t            state, state_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [ATTR_W-1:0] attr;
  logic [CNT_W-1:0]  src, src_next;
  logic              wr_valid, wr_valid_next;
  logic [ADDR_W-1:0] wr_addr, wr_addr_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic              fill_reset, fill_reset_next;
  logic              pend_scroll, pend_scroll_next;

  // Memory port signals.
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  // Result emission.
  logic              emit;
  logic [CELL_W-1:0] emit_cell;
  logic              emit_scroll;

  logic              accept;
  logic [COL_W-1:0]  clamp_col;
  logic [ROW_W-1:0]  clamp_row;
  logic              row_inc;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Targets beyond the grid clamp to the last column or row.
  assign clamp_col = (target_col >= COL_W'(COLUMNS)) ? COL_W'(COLUMNS - 1) : target_col;
  assign clamp_row = (target_row >= ROW_W'(ROWS)) ? ROW_W'(ROWS - 1) : target_row;

  tcw_cell_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // State and cursor registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_FILL;
      cur_col     <= '0;
      cur_row     <= '0;
      src         <= '0;
      wr_valid    <= 1'b0;
      ptr         <= '0;
      fill_reset  <= 1'b1;
      pend_scroll <= 1'b0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      cur_col     <= cur_col_next;
      cur_row     <= cur_row_next;
      src         <= src_next;
      wr_valid    <= wr_valid_next;
      ptr         <= ptr_next;
      fill_reset  <= fill_reset_next;
      pend_scroll <= pend_scroll_next;
      done        <= emit;
    end
  end

  // Copy destination needs no reset.
  always_ff @(posedge clk) begin
    wr_addr <= wr_addr_next;
  end

  // Attribute register.
  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= RESET_ATTR;
    end else if (cfg_valid && cfg_ready) begin
      attr <= color_attribute;
    end
  end

  // Result registers, loaded when a result is emitted.
  always_ff @(posedge clk) begin
    if (emit) begin
      cursor_col      <= cur_col_next;
      cursor_row      <= cur_row_next;
      cursor_position <= POS_W'(cell_addr(cur_col_next, cur_row_next));
      cell_data       <= emit_cell;
      scrolled        <= emit_scroll;
    end
  end

  // Next state, cursor update and memory access.
  always_comb begin
    state_next       = state;
    cur_col_next     = cur_col;
    cur_row_next     = cur_row;
    src_next         = src;
    wr_valid_next    = wr_valid;
    wr_addr_next     = wr_addr;
    ptr_next         = ptr;
    fill_reset_next  = fill_reset;
    pend_scroll_next = pend_scroll;
    mem_we           = 1'b0;
    mem_waddr        = cell_addr(cur_col, cur_row);
    mem_wdata        = {attr, CH_BLANK};
    mem_raddr        = '0;
    emit             = 1'b0;
    emit_cell        = '0;
    emit_scroll      = 1'b0;
    row_inc          = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (opcode)
            OP_PUT: begin
              case (char_code)
                CH_LF: begin
                  cur_col_next = '0;
                  row_inc      = 1'b1;
                end
                CH_CR: begin
                  cur_col_next = '0;
                end
                CH_BS: begin
                  // Backspace at the first column leaves everything as it is.
                  if (cur_col != '0) begin
                    cur_col_next = cur_col - COL_W'(1);
                    mem_we       = 1'b1;
                    mem_waddr    = cell_addr(cur_col_next, cur_row);
                  end
                end
                default: begin
                  mem_we    = 1'b1;
                  mem_wdata = {attr, char_code};
                  if (cur_col == COL_W'(COLUMNS - 1)) begin
                    cur_col_next = '0;
                    row_inc      = 1'b1;
                  end else begin
                    cur_col_next = cur_col + COL_W'(1);
                  end
                end
              endcase
              if (row_inc && (cur_row == ROW_W'(ROWS - 1))) begin
                // Moving past the bottom row starts a scroll.
                cur_row_next     = ROW_W'(ROWS - 1);
                pend_scroll_next = 1'b1;
                fill_reset_next  = 1'b0;
                src_next         = CNT_W'(COLUMNS);
                wr_valid_next    = 1'b0;
                state_next       = ST_COPY;
              end else begin
                if (row_inc) begin
                  cur_row_next = cur_row + ROW_W'(1);
                end
                emit = 1'b1;
              end
            end
            OP_CLEAR: begin
              cur_col_next     = '0;
              cur_row_next     = '0;
              ptr_next         = '0;
              fill_reset_next  = 1'b0;
              pend_scroll_next = 1'b0;
              state_next       = ST_FILL;
            end
            OP_SET: begin
              cur_col_next = clamp_col;
              cur_row_next = clamp_row;
              emit         = 1'b1;
            end
            default: begin
              mem_raddr  = cell_addr(clamp_col, clamp_row);
              state_next = ST_READ;
            end
          endcase
        end
      end

      ST_READ: begin
        emit       = 1'b1;
        emit_cell  = mem_rdata;
        state_next = ST_IDLE;
      end

      ST_COPY: begin
        // Write back the cell read in the previous cycle one row higher.
        if (wr_valid) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr;
          mem_wdata = mem_rdata;
        end
        if (src == CNT_W'(CELL_COUNT)) begin
          wr_valid_next = 1'b0;
          ptr_next      = ADDR_W'((ROWS - 1) * COLUMNS);
          state_next    = ST_FILL;
        end else begin
          mem_raddr     = src[ADDR_W-1:0];
          wr_addr_next  = ADDR_W'(src - CNT_W'(COLUMNS));
          wr_valid_next = 1'b1;
          src_next      = src + CNT_W'(1);
        end
      end

      ST_FILL: begin
        // Blank one cell per cycle up to the end of the grid.
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = {(fill_reset ? RESET_ATTR : attr), CH_BLANK};
        if (ptr == ADDR_W'(CELL_COUNT - 1)) begin
          state_next  = ST_IDLE;
          emit        = !fill_reset;
          emit_scroll = pend_scroll;
        end else begin
          ptr_next = ptr + ADDR_W'(1);
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/tcw_checker.sv @@
// Port-level checks of the text console writer and their binding to the top level.
`include "text_console_writer_defines.svh"

module tcw_port_checks (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic [tcw_pkg::OP_W-1:0]    opcode,
  input logic                        done,
  input logic [tcw_pkg::COL_W-1:0]   cursor_col,
  input logic [tcw_pkg::ROW_W-1:0]   cursor_row,
  input logic [tcw_pkg::POS_W-1:0]   cursor_position,
  input logic [tcw_pkg::CELL_W-1:0]  cell_data,
  input logic                        scrolled
);
  import tcw_pkg::*;

  // The cursor reported in a result beat stays on the grid.
  `TCW_ASSERT_IMPLY(a_cursor_on_grid, clk, rst, done,
                    (cursor_col < COL_W'(COLUMNS)) && (cursor_row < ROW_W'(ROWS)))

  // The linear position agrees with the reported column and row.
  `TCW_ASSERT_IMPLY(a_position_match, clk, rst, done,
                    cursor_position == POS_W'(cell_addr(cursor_col, cursor_row)))

  // A scroll leaves the cursor on the last row.
  `TCW_ASSERT_IMPLY(a_scroll_last_row, clk, rst, done && scrolled,
                    cursor_row == ROW_W'(ROWS - 1))

  // Set cursor answers in the next cycle with no scroll and no cell data.
  `TCW_ASSERT_NEXT(a_set_one_cycle, clk, rst, start && !busy && (opcode == OP_SET),
                   done && !scrolled && (cell_data == '0))

endmodule

bind text_console_writer tcw_port_checks u_tcw_port_checks (.*);
